/* src/tlfl_pkg.sv */
// shared types, constants and tables for the track length block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tlfl_pkg;

  localparam int FRAC_BITS         = 16;
  localparam int CORDIC_ITERATIONS = 24;
  localparam int SCALE_SH          = 30 - FRAC_BITS;
  localparam int COORD_W           = 18 + FRAC_BITS;

  localparam int MD_W    = 30;
  localparam int MAG_W   = 27;
  localparam int NUM_W   = 59;
  localparam int QUOT_W  = 31;
  localparam int DREM_W  = 30;
  localparam int ANGLE_W = 34;
  localparam int TRIG_W  = 32;
  localparam int Q_W     = 34;
  localparam int CNT_W   = 6;

  localparam int RAD_W   = 16;
  localparam int SEG_W   = 33;
  localparam int SUM_W   = 48;
  localparam int PCNT_W  = 32;

  localparam int ABS_W   = COORD_W;
  localparam int HALF_W  = (ABS_W + 1) / 2;
  localparam int PAD_W   = 2 * HALF_W;
  localparam int ACC_W   = 2 * PAD_W + 2;
  localparam int ROOT_W  = ACC_W / 2;

  // reciprocal estimate, remainder, two corrections
  localparam int DIV_STEPS  = 4;
  localparam int SQRT_STEPS = ROOT_W;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(6378);
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [ANGLE_W-1:0] CORDIC_K = ANGLE_W'(652032874);
  localparam logic [DREM_W-1:0] DIV_CONST = DREM_W'(180000000);
  localparam logic [NUM_W-1:0] DIV_HALF = NUM_W'(90000000);
  localparam logic [31:0] DIV_RECIP = 32'((64'd1 << NUM_W) / 64'd180000000);

  localparam logic signed [MD_W-1:0] MD_90  = MD_W'(90000000);
  localparam logic signed [MD_W-1:0] MD_180 = MD_W'(180000000);
  localparam logic signed [MD_W-1:0] MD_360 = MD_W'(360000000);

  localparam logic [SEG_W-1:0]  SEG_MAX   = {SEG_W{1'b1}};
  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [PCNT_W-1:0] PCNT_MAX  = {PCNT_W{1'b1}};

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_PREP, OP_MUL, OP_DIV, OP_CINIT, OP_CORDIC, OP_TSTORE,
    OP_TMUL, OP_SCALE, OP_DIFF, OP_SQ, OP_SINIT, OP_SQRT, OP_UPDATE
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL, S_DIV, S_CINIT, S_CORDIC, S_TSTORE, S_TMUL,
    S_SCALE, S_DIFF, S_SQ, S_SINIT, S_SQRT, S_UPDATE
  } state_t;

  typedef struct packed {
    op_t        op;
    logic       sel;
    logic [4:0] step;
    logic [1:0] axis;
    logic [1:0] part;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  // atan(2^-i) in q30
  function automatic logic signed [ANGLE_W-1:0] atan_q30(input logic [4:0] i);
    logic signed [ANGLE_W-1:0] v;
    case (i)
      5'd0:    v = ANGLE_W'(843314857);
      5'd1:    v = ANGLE_W'(497837829);
      5'd2:    v = ANGLE_W'(263043837);
      5'd3:    v = ANGLE_W'(133525159);
      5'd4:    v = ANGLE_W'(67021687);
      5'd5:    v = ANGLE_W'(33543516);
      5'd6:    v = ANGLE_W'(16775851);
      5'd7:    v = ANGLE_W'(8388437);
      5'd8:    v = ANGLE_W'(4194283);
      5'd9:    v = ANGLE_W'(2097149);
      5'd10:   v = ANGLE_W'(1048576);
      5'd31:   v = '0;
      default: v = ANGLE_W'(1) <<< (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* src/tlfl_ctrl.sv */
// controller state machine sequencing the datapath per track point
// depends on tlfl_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlfl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire tlfl_pkg::status_t status,
  output tlfl_pkg::cmd_t        cmd
);
  import tlfl_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             sel_r, sel_nxt;
  logic [1:0]       axis_r, axis_nxt;
  logic [1:0]       part_r, part_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      sel_r   <= 1'b0;
      axis_r  <= '0;
      part_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sel_r   <= sel_nxt;
      axis_r  <= axis_nxt;
      part_r  <= part_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    axis_nxt  = axis_r;
    part_nxt  = part_r;
    in_stall  = 1'b1;
    cmd.op    = OP_NONE;
    cmd.sel   = sel_r;
    cmd.step  = cnt_r[4:0];
    cmd.axis  = axis_r;
    cmd.part  = part_r;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          sel_nxt   = 1'b0;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.op    = OP_PREP;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.op    = OP_MUL;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = OP_DIV;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_CINIT;
        end
      end
      S_CINIT: begin
        cmd.op    = OP_CINIT;
        cnt_nxt   = '0;
        state_nxt = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.op  = OP_CORDIC;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(CORDIC_ITERATIONS - 1)) begin
          state_nxt = S_TSTORE;
        end
      end
      S_TSTORE: begin
        cmd.op = OP_TSTORE;
        if (!sel_r) begin
          sel_nxt   = 1'b1;
          state_nxt = S_PREP;
        end else begin
          axis_nxt  = '0;
          state_nxt = S_TMUL;
        end
      end
      S_TMUL: begin
        cmd.op    = OP_TMUL;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.op = OP_SCALE;
        if (axis_r == 2'd2) begin
          axis_nxt  = '0;
          state_nxt = S_DIFF;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_TMUL;
        end
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        part_nxt  = '0;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (part_r == 2'd2) begin
          if (axis_r == 2'd2) begin
            state_nxt = S_SINIT;
          end else begin
            axis_nxt  = axis_r + 2'd1;
            state_nxt = S_DIFF;
          end
        end else begin
          part_nxt = part_r + 2'd1;
        end
      end
      S_SINIT: begin
        cmd.op    = OP_SINIT;
        cnt_nxt   = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.op  = OP_SQRT;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (!status.out_busy) begin
          cmd.op    = OP_UPDATE;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/tlfl_datapath.sv */
// datapath: angle scaling by reciprocal division, cordic, coordinate scaling,
// squares, square root, track state and result register; depends on tlfl_pkg
`timescale 1ns / 1ps
`default_nettype none

module tlfl_datapath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire tlfl_pkg::cmd_t                  cmd,
  output tlfl_pkg::status_t                    status,
  input  wire logic [tlfl_pkg::RAD_W-1:0]      radius,
  input  wire logic                            in_restart,
  input  wire logic signed [27:0]              in_latitude_microdeg,
  input  wire logic signed [28:0]              in_longitude_microdeg,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [tlfl_pkg::SEG_W-1:0]           out_segment_length,
  output logic [tlfl_pkg::SUM_W-1:0]           out_total_length,
  output logic [tlfl_pkg::PCNT_W-1:0]          out_point_count,
  output logic                                 out_first_point
);
  import tlfl_pkg::*;

  logic                       restart_r;
  logic signed [27:0]         lat_r;
  logic signed [28:0]         lon_r;
  logic [MAG_W-1:0]           mag_r;
  logic                       neg_r, angneg_r;
  logic [NUM_W-1:0]           num_r;
  logic [DREM_W-1:0]          drem_r;
  logic [QUOT_W-1:0]          quo_r;
  logic signed [ANGLE_W-1:0]  x_r, y_r, z_r;
  logic signed [TRIG_W-1:0]   cla_r, sla_r, clo_r, slo_r;
  logic signed [Q_W-1:0]      q_r;
  logic signed [COORD_W-1:0]  cur_r [3];
  logic signed [COORD_W-1:0]  prev_r [3];
  logic [PAD_W-1:0]           abs_r;
  logic [ACC_W-1:0]           acc_r;
  logic [ACC_W-1:0]           src_r;
  logic [ROOT_W:0]            srem_r;
  logic [ROOT_W-1:0]          root_r;
  logic                       have_prev_r;
  logic [SUM_W-1:0]           sum_r;
  logic [PCNT_W-1:0]          pcnt_r;
  logic                       out_valid_r;
  logic [SEG_W-1:0]           seg_out_r;
  logic [SUM_W-1:0]           sum_out_r;
  logic [PCNT_W-1:0]          pcnt_out_r;
  logic                       first_out_r;

  // angle wrap and fold
  logic signed [MD_W-1:0] md, md_w, md_f;
  logic                   fold_neg, ang_neg;
  logic [MAG_W-1:0]       mag;
  always_comb begin
    md = cmd.sel ? MD_W'(lon_r) : MD_W'(lat_r);
    if (md > MD_180) begin
      md_w = md - MD_360;
    end else if (md < -MD_180) begin
      md_w = md + MD_360;
    end else begin
      md_w = md;
    end
    fold_neg = 1'b1;
    if (md_w > MD_90) begin
      md_f = md_w - MD_180;
    end else if (md_w < -MD_90) begin
      md_f = md_w + MD_180;
    end else begin
      md_f     = md_w;
      fold_neg = 1'b0;
    end
    ang_neg = md_f[MD_W-1];
    mag     = ang_neg ? MAG_W'(-md_f) : MAG_W'(md_f);
  end

  // radians q30 numerator, reciprocal estimate and remainder correction
  logic [NUM_W-1:0]  num;
  logic [63:0]       rprod;
  logic [NUM_W-1:0]  qprod;
  logic              dge;
  always_comb begin
    num   = NUM_W'(mag_r) * NUM_W'(PI_Q30) + DIV_HALF;
    rprod = 64'(num_r[NUM_W-1 -: 32]) * 64'(DIV_RECIP);
    qprod = NUM_W'(quo_r) * NUM_W'(DIV_CONST);
    dge   = drem_r >= DIV_CONST;
  end

  // cordic rotation step
  logic signed [ANGLE_W-1:0] sx, sy, at;
  always_comb begin
    sx = x_r >>> cmd.step;
    sy = y_r >>> cmd.step;
    at = atan_q30(cmd.step);
  end

  // trig product and radius scaling
  logic signed [TRIG_W-1:0]  tm_b;
  logic signed [63:0]        tprod, tround;
  logic signed [Q_W-1:0]     qv;
  logic signed [50:0]        sprod, sround;
  always_comb begin
    tm_b   = (cmd.axis == 2'd0) ? clo_r : slo_r;
    tprod  = cla_r * tm_b;
    tround = (tprod + (64'sd1 <<< 29)) >>> 30;
    qv     = (cmd.axis == 2'd2) ? Q_W'(sla_r) : tround[Q_W-1:0];
    sprod  = q_r * $signed({1'b0, radius});
    sround = (sprod + (51'sd1 <<< (SCALE_SH - 1))) >>> SCALE_SH;
  end

  // coordinate difference and partial squares
  logic signed [COORD_W:0] dv;
  logic [PAD_W-1:0]        dabs;
  logic [HALF_W-1:0]       ma, mb;
  logic [PAD_W-1:0]        pp;
  logic [ACC_W-1:0]        addend;
  always_comb begin
    dv   = $signed({cur_r[cmd.axis][COORD_W-1], cur_r[cmd.axis]})
         - $signed({prev_r[cmd.axis][COORD_W-1], prev_r[cmd.axis]});
    dabs = dv[COORD_W] ? PAD_W'(-dv) : PAD_W'(dv);
    ma   = (cmd.part == 2'd0) ? abs_r[HALF_W-1:0] : abs_r[PAD_W-1:HALF_W];
    mb   = (cmd.part == 2'd2) ? abs_r[PAD_W-1:HALF_W] : abs_r[HALF_W-1:0];
    pp   = PAD_W'(ma) * PAD_W'(mb);
    case (cmd.part)
      2'd0:    addend = ACC_W'(pp);
      2'd1:    addend = ACC_W'(pp) << (HALF_W + 1);
      2'd2:    addend = ACC_W'(pp) << (2 * HALF_W);
      default: addend = '0;
    endcase
  end

  // square root digit step
  logic [ROOT_W+2:0] srem2, trial;
  logic              sge;
  always_comb begin
    srem2 = {srem_r, src_r[ACC_W-1 -: 2]};
    trial = {1'b0, root_r, 2'b01};
    sge   = srem2 >= trial;
  end

  // result of this point
  logic              first;
  logic [SEG_W-1:0]  seg;
  logic [SUM_W-1:0]  sum_base;
  logic [SUM_W:0]    sum_new;
  logic [PCNT_W-1:0] pcnt_base;
  always_comb begin
    first     = restart_r | ~have_prev_r;
    if (first) begin
      seg = '0;
    end else if (root_r > ROOT_W'(SEG_MAX)) begin
      seg = SEG_MAX;
    end else begin
      seg = SEG_W'(root_r);
    end
    sum_base  = restart_r ? '0 : sum_r;
    pcnt_base = restart_r ? '0 : pcnt_r;
    sum_new   = {1'b0, sum_base} + (SUM_W + 1)'(seg);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        restart_r <= in_restart;
        lat_r     <= in_latitude_microdeg;
        lon_r     <= in_longitude_microdeg;
      end
      OP_PREP: begin
        mag_r    <= mag;
        neg_r    <= fold_neg;
        angneg_r <= ang_neg;
      end
      OP_MUL: begin
        num_r <= num;
      end
      OP_DIV: begin
        if (cmd.step == 5'd0) begin
          quo_r <= rprod[32 +: QUOT_W];
        end else if (cmd.step == 5'd1) begin
          drem_r <= DREM_W'(num_r - qprod);
        end else if (dge) begin
          drem_r <= drem_r - DIV_CONST;
          quo_r  <= quo_r + QUOT_W'(1);
        end
      end
      OP_CINIT: begin
        x_r <= CORDIC_K;
        y_r <= '0;
        z_r <= angneg_r ? -$signed(ANGLE_W'(quo_r)) : $signed(ANGLE_W'(quo_r));
      end
      OP_CORDIC: begin
        if (!z_r[ANGLE_W-1]) begin
          x_r <= x_r - sy;
          y_r <= y_r + sx;
          z_r <= z_r - at;
        end else begin
          x_r <= x_r + sy;
          y_r <= y_r - sx;
          z_r <= z_r + at;
        end
      end
      OP_TSTORE: begin
        if (cmd.sel) begin
          clo_r <= neg_r ? TRIG_W'(-x_r) : TRIG_W'(x_r);
          slo_r <= neg_r ? TRIG_W'(-y_r) : TRIG_W'(y_r);
        end else begin
          cla_r <= neg_r ? TRIG_W'(-x_r) : TRIG_W'(x_r);
          sla_r <= neg_r ? TRIG_W'(-y_r) : TRIG_W'(y_r);
        end
      end
      OP_TMUL: begin
        q_r <= qv;
      end
      OP_SCALE: begin
        cur_r[cmd.axis] <= sround[COORD_W-1:0];
      end
      OP_DIFF: begin
        abs_r <= dabs;
        if (cmd.axis == 2'd0) begin
          acc_r <= '0;
        end
      end
      OP_SQ: begin
        acc_r <= acc_r + addend;
      end
      OP_SINIT: begin
        src_r  <= acc_r;
        srem_r <= '0;
        root_r <= '0;
      end
      OP_SQRT: begin
        src_r  <= src_r << 2;
        srem_r <= sge ? (ROOT_W + 1)'(srem2 - trial) : (ROOT_W + 1)'(srem2);
        root_r <= {root_r[ROOT_W-2:0], sge};
      end
      OP_UPDATE: begin
        prev_r[0]   <= cur_r[0];
        prev_r[1]   <= cur_r[1];
        prev_r[2]   <= cur_r[2];
        seg_out_r   <= seg;
        sum_out_r   <= sum_new[SUM_W] ? SUM_MAX : sum_new[SUM_W-1:0];
        pcnt_out_r  <= (pcnt_base == PCNT_MAX) ? PCNT_MAX : pcnt_base + PCNT_W'(1);
        first_out_r <= first;
      end
      default: begin
      end
    endcase
  end

  // track state and result handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_prev_r <= 1'b0;
      sum_r       <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_UPDATE) begin
        have_prev_r <= 1'b1;
        sum_r       <= sum_new[SUM_W] ? SUM_MAX : sum_new[SUM_W-1:0];
        pcnt_r      <= (pcnt_base == PCNT_MAX) ? PCNT_MAX : pcnt_base + PCNT_W'(1);
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_busy    = out_valid_r & out_stall;
  assign out_valid          = out_valid_r;
  assign out_segment_length = seg_out_r;
  assign out_total_length   = sum_out_r;
  assign out_point_count    = pcnt_out_r;
  assign out_first_point    = first_out_r;

endmodule

`default_nettype wire

/* src/track_length_from_latlon_top.sv */
// top level: configuration register, controller and datapath
// depends on tlfl_pkg, tlfl_ctrl, tlfl_datapath
`timescale 1ns / 1ps
`default_nettype none

// Converts each latitude/longitude point to x, y, z on a sphere of the
// programmed radius and reports the chord to the previous point (Q.16 km),
// the saturating running total and the point count; in_restart begins a new
// track. One point at a time: the next point is taken only after the result
// of the last is in the output register. Each point runs the 4-step angle
// division (reciprocal estimate, remainder and two corrections) and 24-step
// cordic once for each angle plus the 35-step square root. A finished result
// waits in the output register and only stalls the following point at its
// last step. The radius register sits at byte address 0; the user must
// write it over the apb port only while the block is idle, which the block
// itself does not enforce.
module track_length_from_latlon_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_restart,
  input  wire logic signed [27:0]            in_latitude_microdeg,
  input  wire logic signed [28:0]            in_longitude_microdeg,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [tlfl_pkg::SEG_W-1:0]         out_segment_length,
  output logic [tlfl_pkg::SUM_W-1:0]         out_total_length,
  output logic [tlfl_pkg::PCNT_W-1:0]        out_point_count,
  output logic                               out_first_point,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import tlfl_pkg::*;

  logic [RAD_W-1:0] radius_r;
  cmd_t             cmd;
  status_t          status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      radius_r <= pwdata[RAD_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : 32'(radius_r);

  tlfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tlfl_datapath u_datapath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .status                (status),
    .radius                (radius_r),
    .in_restart            (in_restart),
    .in_latitude_microdeg  (in_latitude_microdeg),
    .in_longitude_microdeg (in_longitude_microdeg),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_segment_length    (out_segment_length),
    .out_total_length      (out_total_length),
    .out_point_count       (out_point_count),
    .out_first_point       (out_first_point)
  );

endmodule

`default_nettype wire
